// ----- rtl/kf_pkg.sv -----
// kf_pkg: shared types and constants for the scalar ar(1) kalman filter core
// no dependencies; imported by the core, the divider and the checker

package kf_pkg;

  localparam int CFG_INDEX_W = 3;

  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

  localparam cfg_index_t CFG_AR_COEF    = 3'd0;
  localparam cfg_index_t CFG_OBS_NOISE  = 3'd1;
  localparam cfg_index_t CFG_PROC_NOISE = 3'd2;
  localparam cfg_index_t CFG_INIT_MEAN  = 3'd3;
  localparam cfg_index_t CFG_INIT_VAR   = 3'd4;

  // divider status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ----- rtl/kf_mul.sv -----
// kf_mul: shared signed multiplier with registered product and round-half-up
// fixed-point scaling; used by the core sequencer for every product

module kf_mul #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                      clk,
  input  logic signed [DATA_WIDTH:0]                opa,
  input  logic signed [DATA_WIDTH:0]                opb,
  output logic signed [2*DATA_WIDTH+1-FRAC_BITS:0]  rnd
);

  localparam int PW = 2 * DATA_WIDTH + 2;

  localparam logic signed [PW-1:0] HALF = PW'(1) <<< (FRAC_BITS - 1);

  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] sum;

  always_ff @(posedge clk) begin
    prod <= PW'(opa) * PW'(opb);
  end

  // floor((p + half) / 2^frac)
  assign sum = prod + HALF;
  assign rnd = sum[PW-1:FRAC_BITS];

endmodule

// ----- rtl/kf_div.sv -----
// kf_div: restoring divider for the gain, one quotient bit per cycle
// numerator must not exceed the denominator; uses kf_pkg for its status type

module kf_div #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [DATA_WIDTH-2:0]         num,
  input  logic [DATA_WIDTH-2:0]         den,
  output kf_pkg::div_stat_t             stat,
  output logic [FRAC_BITS:0]            quot
);

  import kf_pkg::*;

  localparam int QW = FRAC_BITS + 1;
  localparam int CW = $clog2(QW);

  logic [DATA_WIDTH-1:0] rem;
  logic [DATA_WIDTH-1:0] diff;
  logic                  ge;
  logic [CW-1:0]         cnt;
  logic                  busy;
  logic                  done;

  assign ge   = rem >= {1'b0, den};
  assign diff = rem - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + CW'(1);
      if (cnt == CW'(QW - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        done <= 1'b0;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= {1'b0, num};
      quot <= '0;
    end else if (busy) begin
      rem  <= ge ? (diff << 1) : (rem << 1);
      quot <= {quot[QW-2:0], ge};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ----- rtl/scalar_ar1_kalman_filter_core.sv -----
// scalar_ar1_kalman_filter_core: top level, sequencer and state of the filter
// depends on kf_pkg, kf_mul and kf_div
//
// usage:
//   in channel: one transaction per observation; tdata carries the signed
//   observation, tuser the start flag that reloads the initial mean and
//   variance before the step.
//   out channel: one transaction per observation with the posterior mean,
//   the posterior variance and the predictive variance.
//   cfg port: single-cycle writes of the five registers, only while idle.
// timing:
//   from acceptance to a valid result, one observation takes five multiplies on
//   the shared multiplier, a few adds and the bit-serial divider that forms the
//   gain. in_tready is high only while the sequencer is idle, so a new
//   observation is taken only after the previous one has finished and its
//   result has gone to the output register.
// reset: synchronous; config registers take their reset values, the filter state
//   takes the initial mean and variance, the output is empty.
// stall: a finished result waits in the sequencer until the output register
//   frees; meanwhile in_tready stays low and no new observation is taken.

module scalar_ar1_kalman_filter_core #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // cfg
  input  logic                                   cfg_en,
  input  kf_pkg::cfg_index_t                     cfg_index,
  input  logic [DATA_WIDTH-1:0]                  cfg_data,
  // in
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [((DATA_WIDTH+7)/8)*8-1:0]        in_tdata,   // observation
  input  logic                                   in_tuser,   // start_series
  // out
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // post_mean, post_var, pred_var
  output logic [((3*DATA_WIDTH-2+7)/8)*8-1:0]    out_tdata
);

  import kf_pkg::*;

  localparam int DW = DATA_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int OW = ((3 * DW - 2 + 7) / 8) * 8;
  localparam int RW = 2 * DW + 2 - F;
  localparam int SW = RW + 1;

  localparam logic [DW-2:0]         VAR_ONE = (DW-1)'(1) << F;
  localparam logic [F:0]            K_ONE   = (F+1)'(1) << F;
  localparam logic signed [SW-1:0]  SMAX_X  = {{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [SW-1:0]  SMIN_X  = {{(SW-DW+1){1'b1}}, {(DW-1){1'b0}}};

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_M1   = 4'd1;
  localparam logic [3:0] S_M2   = 4'd2;
  localparam logic [3:0] S_M3   = 4'd3;
  localparam logic [3:0] S_M4   = 4'd4;
  localparam logic [3:0] S_M5   = 4'd5;
  localparam logic [3:0] S_R    = 4'd6;
  localparam logic [3:0] S_Q    = 4'd7;
  localparam logic [3:0] S_DS   = 4'd8;
  localparam logic [3:0] S_DW   = 4'd9;
  localparam logic [3:0] S_K    = 4'd10;
  localparam logic [3:0] S_T    = 4'd11;
  localparam logic [3:0] S_U    = 4'd12;
  localparam logic [3:0] S_DONE = 4'd13;

  function automatic logic signed [DW-1:0] sat_s(input logic signed [SW-1:0] x);
    if (x > SMAX_X) begin
      sat_s = {1'b0, {(DW-1){1'b1}}};
    end else if (x < SMIN_X) begin
      sat_s = {1'b1, {(DW-1){1'b0}}};
    end else begin
      sat_s = x[DW-1:0];
    end
  endfunction

  function automatic logic [DW-2:0] sat_v(input logic signed [SW-1:0] x);
    if (x < 0) begin
      sat_v = '0;
    end else if (x > SMAX_X) begin
      sat_v = '1;
    end else begin
      sat_v = x[DW-2:0];
    end
  endfunction

  function automatic logic [DW-2:0] sat_add(input logic [DW-2:0] x, input logic [DW-2:0] y);
    logic [DW-1:0] s;
    s = {1'b0, x} + {1'b0, y};
    sat_add = s[DW-1] ? '1 : s[DW-2:0];
  endfunction

  // configuration registers
  logic signed [DW-1:0] ar_coef;
  logic [DW-2:0]        obs_noise;
  logic [DW-2:0]        proc_noise;
  logic signed [DW-1:0] init_mean;
  logic [DW-2:0]        init_var;

  // filter state and working registers
  logic [3:0]           state;
  logic signed [DW-1:0] state_mean;
  logic [DW-2:0]        state_var;
  logic signed [DW-1:0] obs;
  logic signed [DW-1:0] pred_mean;
  logic [DW-2:0]        phi2;
  logic [DW-2:0]        r;
  logic [DW-2:0]        q;
  logic signed [DW:0]   innov;
  logic [F:0]           k;
  logic signed [RW-1:0] t;

  logic signed [DW:0]   opa;
  logic signed [DW:0]   opb;
  logic signed [RW-1:0] rnd;
  logic signed [SW-1:0] rnd_x;
  logic                 div_start;
  div_stat_t            div_stat;
  logic [F:0]           quot;
  logic                 out_free;

  kf_mul #(
    .DATA_WIDTH (DW),
    .FRAC_BITS  (F)
  ) u_mul (
    .clk (clk),
    .opa (opa),
    .opb (opb),
    .rnd (rnd)
  );

  kf_div #(
    .DATA_WIDTH (DW),
    .FRAC_BITS  (F)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (r),
    .den   (q),
    .stat  (div_stat),
    .quot  (quot)
  );

  assign rnd_x     = SW'(rnd);
  assign in_tready = (state == S_IDLE);
  assign div_start = (state == S_DS);
  assign out_free  = !out_tvalid || out_tready;

  // operand select for the shared multiplier
  always_comb begin
    opa = '0;
    opb = '0;
    case (state)
      S_M1: begin
        opa = (DW+1)'(ar_coef);
        opb = (DW+1)'(state_mean);
      end
      S_M2: begin
        opa = (DW+1)'(ar_coef);
        opb = (DW+1)'(ar_coef);
      end
      S_M4: begin
        opa = signed'({2'b00, phi2});
        opb = signed'({2'b00, state_var});
      end
      S_K: begin
        opa = signed'((DW+1)'(k));
        opb = innov;
      end
      S_T: begin
        opa = signed'((DW+1)'(K_ONE - k));
        opb = signed'({2'b00, r});
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ar_coef    <= '0;
      obs_noise  <= VAR_ONE;
      proc_noise <= VAR_ONE;
      init_mean  <= '0;
      init_var   <= VAR_ONE;
    end else if (cfg_en) begin
      case (cfg_index)
        CFG_AR_COEF:    ar_coef    <= cfg_data;
        CFG_OBS_NOISE:  obs_noise  <= cfg_data[DW-2:0];
        CFG_PROC_NOISE: proc_noise <= cfg_data[DW-2:0];
        CFG_INIT_MEAN:  init_mean  <= cfg_data;
        CFG_INIT_VAR:   init_var   <= cfg_data[DW-2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      state_mean <= '0;
      state_var  <= VAR_ONE;
      out_tvalid <= 1'b0;
    end else begin
      if (out_tvalid && out_tready && state != S_DONE) begin
        out_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_tvalid) begin
            state <= S_M1;
            if (in_tuser) begin
              state_mean <= init_mean;
              state_var  <= init_var;
            end
          end
        end
        S_M1: state <= S_M2;
        S_M2: state <= S_M3;
        S_M3: state <= S_M4;
        S_M4: state <= S_M5;
        S_M5: state <= S_R;
        S_R:  state <= S_Q;
        S_Q:  state <= S_DS;
        S_DS: state <= S_DW;
        S_DW: begin
          if (div_stat.done) begin
            state <= S_K;
          end
        end
        S_K: state <= S_T;
        S_T: state <= S_U;
        S_U: begin
          state      <= S_DONE;
          state_mean <= sat_s(SW'(pred_mean) + SW'(t));
          state_var  <= sat_v(rnd_x);
        end
        S_DONE: begin
          if (out_free) begin
            state      <= S_IDLE;
            out_tvalid <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_tvalid) begin
          obs <= in_tdata[DW-1:0];
        end
      end
      S_M2: pred_mean <= sat_s(rnd_x);
      S_M3: phi2 <= sat_v(rnd_x);
      S_M5: r <= sat_v(rnd_x);
      S_R:  r <= sat_add(r, proc_noise);
      S_Q: begin
        q     <= sat_add(r, obs_noise);
        innov <= (DW+1)'(obs) - (DW+1)'(pred_mean);
      end
      S_DW: begin
        if (div_stat.done) begin
          k <= (q == '0) ? '0 : quot;
        end
      end
      S_T: t <= rnd;
      S_DONE: begin
        if (out_free) begin
          out_tdata <= OW'({q, state_var, state_mean});
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/kf_checker.sv -----
// kf_checker: port-level assertions for scalar_ar1_kalman_filter_core
// bound to the core at the end of this file; depends on kf_pkg

module kf_checker #(
  parameter int DATA_WIDTH = 32
) (
  input logic                                clk,
  input logic                                rst,
  input logic                                cfg_en,
  input kf_pkg::cfg_index_t                  cfg_index,
  input logic                                in_tvalid,
  input logic                                in_tready,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [((3*DATA_WIDTH-2+7)/8)*8-1:0] out_tdata
);

  import kf_pkg::*;

  localparam int DW = DATA_WIDTH;

  logic [DW-2:0] post_var;
  logic [DW-2:0] pred_var;
  logic          init_var_wr;

  assign post_var    = out_tdata[2*DW-2:DW];
  assign pred_var    = out_tdata[3*DW-3:2*DW-1];
  assign init_var_wr = cfg_en && (cfg_index == CFG_INIT_VAR);

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_tvalid)
    else $error("output valid after reset");

  // a stalled result is held
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output transaction dropped or changed");

  // an accepted observation makes the core busy
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready right after acceptance");

  // a new result appears only as the sequencer returns to idle
  a_rise_idle: assert property (@(posedge clk) disable iff (rst || init_var_wr)
    $rose(out_tvalid) |-> in_tready)
    else $error("result raised while busy");

  // posterior variance never exceeds predictive variance
  a_var_order: assert property (@(posedge clk) disable iff (rst)
    out_tvalid |-> post_var <= pred_var)
    else $error("posterior variance above predictive variance");

endmodule

bind scalar_ar1_kalman_filter_core kf_checker #(
  .DATA_WIDTH (DATA_WIDTH)
) u_kf_checker (
  .clk        (clk),
  .rst        (rst),
  .cfg_en     (cfg_en),
  .cfg_index  (cfg_index),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
